[sv/pfair_pkg.sv]
// Package with the shared types, constants and the letter normalizer of the Playfair unit.
package pfair_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int RC_W        = $clog2(SQUARE_SIDE);
    localparam int LETTERS     = 26;
    localparam int LET_W       = 5;

    localparam logic [LET_W-1:0] LET_I   = LET_W'(8);
    localparam logic [LET_W-1:0] LET_J   = LET_W'(9);
    localparam logic [LET_W-1:0] LET_X   = LET_W'(23);
    localparam logic [LET_W-1:0] LET_Z   = LET_W'(LETTERS - 1);
    localparam logic [6:0]       ASCII_A = 7'd65;

    localparam logic [1:0] FUNC_KEY     = 2'd0;
    localparam logic [1:0] FUNC_END     = 2'd1;
    localparam logic [1:0] FUNC_DIGRAPH = 2'd2;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_INCOMPLETE = 2'd1;
    localparam logic [1:0] STAT_NONLETTER  = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } req_t;

    typedef struct packed {
        logic [6:0] cipher_first;
        logic [6:0] cipher_second;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        logic key_load;
        logic fill_start;
        logic fill_step;
        logic dig_load;
        logic sq_read;
        logic out_valid;
    } ctl_cmd_t;

    typedef struct packed {
        logic fill_last;
    } dp_stat_t;

    typedef struct packed {
        logic             ok;
        logic [LET_W-1:0] idx;
    } letter_t;

    typedef struct packed {
        logic [RC_W-1:0] row;
        logic [RC_W-1:0] col;
    } pos_t;

    function automatic letter_t norm_letter(input logic [7:0] raw);
        logic [7:0] up;
        letter_t    res;
        up = raw;
        if (raw >= 8'd97 && raw <= 8'd122)
        begin
            up = raw - 8'd32;
        end
        res.ok  = (up >= 8'd65) && (up <= 8'd90);
        res.idx = LET_W'(up - 8'd65);
        if (!res.ok)
        begin
            res.idx = '0;
        end
        else if (res.idx == LET_J)
        begin
            res.idx = LET_I;
        end
        return res;
    endfunction

endpackage

[sv/playfair_digraph_cipher_unit.sv]
// Top level of the Playfair digraph cipher unit.
// A request is taken when start is high and busy is low. A key byte or an
// unused function code leaves busy low and gives no result. An end-of-key
// request walks all 26 letters, one per cycle, with busy high until the
// walk ends. A digraph request first reads both letter positions from the
// position map, then reads both cipher letters from the key square, and
// then shows the result with done high.
// The result is valid for that single cycle only, since the receiver cannot
// stall, and must be captured then.
module playfair_digraph_cipher_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pfair_pkg::req_t   req,
    output logic              busy,
    output logic              done,
    output pfair_pkg::rsp_t   result
);

    pfair_pkg::ctl_cmd_t cmd;
    pfair_pkg::dp_stat_t stat;

    pfair_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (req.func),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    pfair_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

    assign done = cmd.out_valid;

endmodule

[sv/pfair_ctrl.sv]
// Controller state machine of the Playfair unit.
module pfair_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            func,
    input  pfair_pkg::dp_stat_t   stat,
    output logic                  busy,
    output pfair_pkg::ctl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FILL = 4'b0010,
        ST_LOOK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.key_load   = accept && (func == pfair_pkg::FUNC_KEY);
        cmd.fill_start = accept && (func == pfair_pkg::FUNC_END);
        cmd.dig_load   = accept && (func == pfair_pkg::FUNC_DIGRAPH);
        cmd.fill_step  = (state_reg == ST_FILL);
        cmd.sq_read    = (state_reg == ST_LOOK);
        cmd.out_valid  = (state_reg == ST_DONE);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.fill_start)
                begin
                    state_next = ST_FILL;
                end
                else if (cmd.dig_load)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_FILL:
            begin
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_done_after_look: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> $past(state_reg == ST_LOOK))
        else $error("result strobe without a preceding lookup");

    a_fill_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && !stat.fill_last) |=> (state_reg == ST_FILL))
        else $error("fill walk left early");

    a_digraph_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dig_load |=> (state_reg == ST_LOOK))
        else $error("digraph request did not start a lookup");
`endif

endmodule

[sv/pfair_dp.sv]
// Datapath of the Playfair unit: key square, letter position map and cipher rules.
module pfair_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pfair_pkg::req_t       req,
    input  pfair_pkg::ctl_cmd_t   cmd,
    output pfair_pkg::dp_stat_t   stat,
    output pfair_pkg::rsp_t       result
);

    localparam int SIDE  = pfair_pkg::SQUARE_SIDE;
    localparam int RC_W  = pfair_pkg::RC_W;
    localparam int LET_W = pfair_pkg::LET_W;

    logic [LET_W-1:0]            sq_mem [SIDE][SIDE];
    pfair_pkg::pos_t             pos_mem [pfair_pkg::LETTERS];

    logic [pfair_pkg::LETTERS-1:0] used_reg;
    logic [RC_W-1:0]             fill_row_reg;
    logic [RC_W-1:0]             fill_col_reg;
    logic [LET_W-1:0]            fill_letter_reg;
    logic                        complete_reg;

    pfair_pkg::pos_t             pos_a_reg;
    pfair_pkg::pos_t             pos_b_reg;
    logic [1:0]                  status_reg;
    logic [LET_W-1:0]            sq_a_reg;
    logic [LET_W-1:0]            sq_b_reg;

    pfair_pkg::letter_t          key_let;
    pfair_pkg::letter_t          a_let;
    pfair_pkg::letter_t          b_let;
    logic [LET_W-1:0]            b_idx;
    logic [1:0]                  status_next;
    logic [LET_W-1:0]            app_letter;
    logic                        app_req;
    logic                        app_en;
    logic                        full;

    pfair_pkg::pos_t             tgt_a;
    pfair_pkg::pos_t             tgt_b;
    logic [RC_W-1:0]             col_a_inc;
    logic [RC_W-1:0]             col_b_inc;
    logic [RC_W-1:0]             row_a_inc;
    logic [RC_W-1:0]             row_b_inc;

    assign stat.fill_last = (fill_letter_reg == pfair_pkg::LET_Z);
    assign full           = (fill_row_reg == RC_W'(SIDE));

    // Key bytes and the end-of-key walk share one append port.
    assign key_let    = pfair_pkg::norm_letter(req.first_byte);
    assign app_letter = cmd.fill_step ? fill_letter_reg : key_let.idx;
    assign app_req    = cmd.fill_step ? (fill_letter_reg != pfair_pkg::LET_J)
                                      : (cmd.key_load && key_let.ok && !complete_reg);
    assign app_en     = app_req && !used_reg[app_letter] && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg        <= '0;
            fill_row_reg    <= '0;
            fill_col_reg    <= '0;
            fill_letter_reg <= '0;
            complete_reg    <= 1'b0;
        end
        else
        begin
            if (app_en)
            begin
                used_reg[app_letter] <= 1'b1;
                if (fill_col_reg == RC_W'(SIDE - 1))
                begin
                    fill_col_reg <= '0;
                    fill_row_reg <= fill_row_reg + 1'b1;
                end
                else
                begin
                    fill_col_reg <= fill_col_reg + 1'b1;
                end
            end
            if (cmd.fill_start)
            begin
                fill_letter_reg <= '0;
            end
            else if (cmd.fill_step)
            begin
                fill_letter_reg <= fill_letter_reg + 1'b1;
                if (stat.fill_last)
                begin
                    complete_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (app_en)
        begin
            sq_mem[fill_row_reg][fill_col_reg] <= app_letter;
            pos_mem[app_letter]                <= '{row: fill_row_reg, col: fill_col_reg};
        end
    end

    // Digraph normalization; an absent or doubled second letter becomes X.
    always_comb
    begin
        a_let = pfair_pkg::norm_letter(req.first_byte);
        b_let = pfair_pkg::norm_letter(req.second_byte);
        b_idx = b_let.idx;
        if (req.second_byte == 8'd0)
        begin
            b_let.ok = 1'b1;
            b_idx    = pfair_pkg::LET_X;
        end
        if (b_idx == a_let.idx)
        begin
            b_idx = pfair_pkg::LET_X;
        end
        priority if (!complete_reg)
        begin
            status_next = pfair_pkg::STAT_INCOMPLETE;
        end
        else if (!a_let.ok || !b_let.ok)
        begin
            status_next = pfair_pkg::STAT_NONLETTER;
        end
        else
        begin
            status_next = pfair_pkg::STAT_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dig_load)
        begin
            pos_a_reg  <= pos_mem[a_let.idx];
            pos_b_reg  <= pos_mem[b_idx];
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        col_a_inc = (pos_a_reg.col == RC_W'(SIDE - 1)) ? '0 : pos_a_reg.col + 1'b1;
        col_b_inc = (pos_b_reg.col == RC_W'(SIDE - 1)) ? '0 : pos_b_reg.col + 1'b1;
        row_a_inc = (pos_a_reg.row == RC_W'(SIDE - 1)) ? '0 : pos_a_reg.row + 1'b1;
        row_b_inc = (pos_b_reg.row == RC_W'(SIDE - 1)) ? '0 : pos_b_reg.row + 1'b1;
        priority if (pos_a_reg.row == pos_b_reg.row)
        begin
            tgt_a = '{row: pos_a_reg.row, col: col_a_inc};
            tgt_b = '{row: pos_b_reg.row, col: col_b_inc};
        end
        else if (pos_a_reg.col == pos_b_reg.col)
        begin
            tgt_a = '{row: row_a_inc, col: pos_a_reg.col};
            tgt_b = '{row: row_b_inc, col: pos_b_reg.col};
        end
        else
        begin
            tgt_a = '{row: pos_a_reg.row, col: pos_b_reg.col};
            tgt_b = '{row: pos_b_reg.row, col: pos_a_reg.col};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sq_read)
        begin
            sq_a_reg <= sq_mem[tgt_a.row][tgt_a.col];
            sq_b_reg <= sq_mem[tgt_b.row][tgt_b.col];
        end
    end

    always_comb
    begin
        result.status        = status_reg;
        result.cipher_first  = '0;
        result.cipher_second = '0;
        if (status_reg == pfair_pkg::STAT_OK)
        begin
            result.cipher_first  = pfair_pkg::ASCII_A + {2'b00, sq_a_reg};
            result.cipher_second = pfair_pkg::ASCII_A + {2'b00, sq_b_reg};
        end
    end

endmodule

[bench/playfair_digraph_cipher_unit_test.sv]
// Self-checking testbench for the Playfair digraph cipher unit.
`timescale 1ns / 1ps

module playfair_digraph_cipher_unit_test;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int CELLS = pfair_pkg::SQUARE_SIDE * pfair_pkg::SQUARE_SIDE;
    localparam int RANDOM_ITEMS = 1130;
    localparam int QUIET_FIRST = 500;
    localparam int QUIET_LAST = 750;
    localparam int IDLE_LIMIT = 500;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        pfair_pkg::req_t req;
        bit              pinned;
        pfair_pkg::rsp_t cipher;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    pfair_pkg::req_t req = '0;
    logic busy;
    logic done;
    pfair_pkg::rsp_t result;

    logic pin_valid = 1'b0;
    pfair_pkg::rsp_t pin_value = '0;

    logic [pfair_pkg::LET_W-1:0] square_cells[CELLS];
    bit letter_taken[pfair_pkg::LETTERS];
    int cells_filled = 0;
    bit square_done = 1'b0;

    pfair_pkg::rsp_t expected_ciphers[$];
    dir_row_t dir_rows[$];

    int mismatches = 0;
    int requests_sent = 0;
    int digraphs_sent = 0;
    int results_checked = 0;
    int quiet_cycles = 0;
    bit activity;
    bit predicted_valid;
    pfair_pkg::rsp_t predicted;
    pfair_pkg::rsp_t got;

    playfair_digraph_cipher_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int letter_of(input logic [7:0] raw);
        int v;
        v = raw;
        if (v >= 97 && v <= 122)
        begin
            v -= 32;
        end
        if (v < 65 || v > 90)
        begin
            return -1;
        end
        v -= 65;
        if (v == pfair_pkg::LET_J)
        begin
            v = pfair_pkg::LET_I;
        end
        return v;
    endfunction

    task automatic place_letter(input int l);
        if (!letter_taken[l] && cells_filled < CELLS)
        begin
            square_cells[cells_filled] = pfair_pkg::LET_W'(l);
            letter_taken[l] = 1'b1;
            cells_filled++;
        end
    endtask

    task automatic cipher_predict(input pfair_pkg::req_t r, output bit produces,
                                  output pfair_pkg::rsp_t o);
        int a;
        int b;
        int pa;
        int pb;
        int ra;
        int ca;
        int rb;
        int cb;
        int oa;
        int ob;
        produces = 1'b0;
        o = '0;
        case (r.func)
            pfair_pkg::FUNC_KEY:
            begin
                if (!square_done)
                begin
                    a = letter_of(r.first_byte);
                    if (a >= 0)
                    begin
                        place_letter(a);
                    end
                end
            end
            pfair_pkg::FUNC_END:
            begin
                for (int l = 0; l < pfair_pkg::LETTERS; l++)
                begin
                    if (l != pfair_pkg::LET_J)
                    begin
                        place_letter(l);
                    end
                end
                square_done = 1'b1;
            end
            pfair_pkg::FUNC_DIGRAPH:
            begin
                produces = 1'b1;
                if (!square_done)
                begin
                    o.status = pfair_pkg::STAT_INCOMPLETE;
                    return;
                end
                a = letter_of(r.first_byte);
                b = (r.second_byte == 8'd0) ? int'(pfair_pkg::LET_X)
                                            : letter_of(r.second_byte);
                if (a < 0 || b < 0)
                begin
                    o.status = pfair_pkg::STAT_NONLETTER;
                    return;
                end
                if (a == b)
                begin
                    b = pfair_pkg::LET_X;
                end
                pa = 0;
                pb = 0;
                for (int p = 0; p < CELLS; p++)
                begin
                    if (square_cells[p] == a)
                    begin
                        pa = p;
                    end
                    if (square_cells[p] == b)
                    begin
                        pb = p;
                    end
                end
                ra = pa / pfair_pkg::SQUARE_SIDE;
                ca = pa % pfair_pkg::SQUARE_SIDE;
                rb = pb / pfair_pkg::SQUARE_SIDE;
                cb = pb % pfair_pkg::SQUARE_SIDE;
                if (ra == rb)
                begin
                    oa = ra * pfair_pkg::SQUARE_SIDE + (ca + 1) % pfair_pkg::SQUARE_SIDE;
                    ob = rb * pfair_pkg::SQUARE_SIDE + (cb + 1) % pfair_pkg::SQUARE_SIDE;
                end
                else if (ca == cb)
                begin
                    oa = ((ra + 1) % pfair_pkg::SQUARE_SIDE) * pfair_pkg::SQUARE_SIDE + ca;
                    ob = ((rb + 1) % pfair_pkg::SQUARE_SIDE) * pfair_pkg::SQUARE_SIDE + cb;
                end
                else
                begin
                    oa = ra * pfair_pkg::SQUARE_SIDE + cb;
                    ob = rb * pfair_pkg::SQUARE_SIDE + ca;
                end
                o.cipher_first = 7'(int'(pfair_pkg::ASCII_A) + int'(square_cells[oa]));
                o.cipher_second = 7'(int'(pfair_pkg::ASCII_A) + int'(square_cells[ob]));
                o.status = pfair_pkg::STAT_OK;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [7:0] letter_byte(input int idx);
        logic [7:0] up;
        up = 8'(65 + idx);
        return $urandom_range(0, 1) ? up : up + 8'd32;
    endfunction

    function automatic int pick_letter();
        return ($urandom_range(0, 7) == 0) ? int'(pfair_pkg::LET_J)
                                           : int'($urandom_range(0, 25));
    endfunction

    task automatic make_random_request(output pfair_pkg::req_t r);
        int mix;
        int a;
        mix = $urandom_range(0, 99);
        a = pick_letter();
        r.func = pfair_pkg::FUNC_DIGRAPH;
        r.first_byte = letter_byte(a);
        r.second_byte = letter_byte(pick_letter());
        if (mix < 8)
        begin
            case ($urandom_range(0, 3))
                0: r.func = pfair_pkg::FUNC_END;
                1: r.func = FUNC_SPARE;
                default: r.func = pfair_pkg::FUNC_KEY;
            endcase
            r.first_byte = 8'($urandom_range(0, 255));
            r.second_byte = 8'($urandom_range(0, 255));
        end
        else if (mix < 14)
        begin
            if ($urandom_range(0, 1))
            begin
                r.first_byte = 8'($urandom_range(0, 255));
            end
            else
            begin
                r.second_byte = 8'($urandom_range(1, 255));
            end
        end
        else if (mix < 24)
        begin
            r.second_byte = 8'd0;
        end
        else if (mix < 34)
        begin
            r.second_byte = letter_byte(a);
        end
    endtask

    task automatic apply_request(input pfair_pkg::req_t r, input bit pin,
                                 input pfair_pkg::rsp_t pin_val, input bit may_idle);
        if (may_idle && $urandom_range(0, 99) < 8)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        pin_valid <= pin;
        pin_value <= pin_val;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic add_row(input logic [1:0] f, input logic [7:0] b0, input logic [7:0] b1,
                           input bit pin, input logic [1:0] stat);
        dir_row_t row;
        row.req = '{func: f, first_byte: b0, second_byte: b1};
        row.pinned = pin;
        row.cipher = '{cipher_first: 7'd0, cipher_second: 7'd0, status: stat};
        dir_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            activity = 1'b0;
            if (done)
            begin
                activity = 1'b1;
                got = result;
                if (expected_ciphers.size() == 0)
                begin
                    $error("result with no request pending: %p", got);
                    mismatches++;
                end
                else
                begin
                    predicted = expected_ciphers.pop_front();
                    results_checked++;
                    if (got.cipher_first !== predicted.cipher_first)
                    begin
                        $error("cipher_first expected %0d actual %0d",
                               predicted.cipher_first, got.cipher_first);
                        mismatches++;
                    end
                    if (got.cipher_second !== predicted.cipher_second)
                    begin
                        $error("cipher_second expected %0d actual %0d",
                               predicted.cipher_second, got.cipher_second);
                        mismatches++;
                    end
                    if (got.status !== predicted.status)
                    begin
                        $error("status expected %0d actual %0d",
                               predicted.status, got.status);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                activity = 1'b1;
                requests_sent++;
                cipher_predict(req, predicted_valid, predicted);
                if (predicted_valid)
                begin
                    digraphs_sent++;
                    expected_ciphers.push_back(pin_valid ? pin_value : predicted);
                end
            end
            quiet_cycles = activity ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("[playfair_digraph_cipher_unit] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        pfair_pkg::req_t r;
        for (int l = 0; l < pfair_pkg::LETTERS; l++)
        begin
            letter_taken[l] = 1'b0;
        end
        for (int p = 0; p < CELLS; p++)
        begin
            square_cells[p] = '0;
        end

        // Digraphs before the square is complete, then key bytes with duplicates,
        // folded J and non-letters, the end of the key twice, and ignored items.
        add_row(pfair_pkg::FUNC_DIGRAPH, "A", "B", 1'b1, pfair_pkg::STAT_INCOMPLETE);
        add_row(pfair_pkg::FUNC_DIGRAPH, 8'h00, 8'hFF, 1'b1, pfair_pkg::STAT_INCOMPLETE);
        add_row(pfair_pkg::FUNC_KEY, "p", 8'h00, 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_KEY, "L", 8'hFF, 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_KEY, "a", 8'h00, 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_KEY, "j", 8'h00, 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_KEY, "i", 8'h00, 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_KEY, "7", 8'h00, 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_KEY, 8'hFF, 8'hFF, 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_KEY, letter_byte(pick_letter()), 8'h00, 1'b0,
                pfair_pkg::STAT_OK);
        add_row(FUNC_SPARE, 8'hFF, 8'hFF, 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_END, 8'h00, 8'h00, 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_END, 8'hFF, 8'hFF, 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_KEY, "Z", 8'h00, 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_DIGRAPH, "H", "E", 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_DIGRAPH, "e", "E", 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_DIGRAPH, "X", "x", 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_DIGRAPH, "J", "j", 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_DIGRAPH, "Q", 8'h00, 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_DIGRAPH, "@", "A", 1'b1, pfair_pkg::STAT_NONLETTER);
        add_row(pfair_pkg::FUNC_DIGRAPH, "A", "[", 1'b1, pfair_pkg::STAT_NONLETTER);
        add_row(pfair_pkg::FUNC_DIGRAPH, "z", "{", 1'b1, pfair_pkg::STAT_NONLETTER);
        add_row(pfair_pkg::FUNC_DIGRAPH, "a", "z", 1'b0, pfair_pkg::STAT_OK);
        add_row(pfair_pkg::FUNC_DIGRAPH, "Z", "A", 1'b0, pfair_pkg::STAT_OK);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            apply_request(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].cipher, 1'b1);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            make_random_request(r);
            apply_request(r, 1'b0, '0, !(i >= QUIET_FIRST && i < QUIET_LAST));
        end
        start <= 1'b0;

        while (expected_ciphers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests, %0d of them digraphs, against one completed key square.",
                 requests_sent, digraphs_sent);
        $display("Checked %0d results, %0d field mismatches.", results_checked, mismatches);
        if (mismatches == 0 && expected_ciphers.size() == 0)
        begin
            $display("[playfair_digraph_cipher_unit] OK");
        end
        else
        begin
            $display("[playfair_digraph_cipher_unit] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/pfair_pkg.sv
sv/pfair_ctrl.sv
sv/pfair_dp.sv
sv/playfair_digraph_cipher_unit.sv
bench/playfair_digraph_cipher_unit_test.sv
